@@ hdl/bilinear_grid_sampler_core_defines.svh @@
// Assertion macros for the bilinear grid sampler RTL.
// Expects clk and rst_n in the scope of every use.
`ifndef BILINEAR_GRID_SAMPLER_CORE_DEFINES_SVH
`define BILINEAR_GRID_SAMPLER_CORE_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define BGS_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define BGS_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/bgs_pkg.sv @@
// Shared types and constants for the bilinear grid sampler.
// No dependencies; used by bilinear_grid_sampler_core.
`default_nettype none

package bgs_pkg;

    localparam int GRID_SIDE_DEF = 64;

    localparam int KIND_W   = 1;
    localparam int CELL_W   = 6;
    localparam int VALUE_W  = 24;
    localparam int POS_W    = 14;
    localparam int FRAC_W   = 8;
    localparam int SIZE_W   = 7;
    localparam int OUT_W    = 32;

    localparam int CELL_X_LSB = 0;
    localparam int CELL_Z_LSB = CELL_X_LSB + CELL_W;
    localparam int VALUE_LSB  = CELL_Z_LSB + CELL_W;
    localparam int POS_X_LSB  = VALUE_LSB + VALUE_W;
    localparam int POS_Z_LSB  = POS_X_LSB + POS_W;
    localparam int IN_DATA_W  = ((POS_Z_LSB + POS_W + 7) / 8) * 8;

    localparam int WGT_W  = POS_W + 1;
    localparam int WP_W   = 2 * WGT_W;
    localparam int TERM_W = WP_W + VALUE_W;
    localparam int ACC_W  = TERM_W + 2;
    localparam int RND_W  = ACC_W + 1;
    localparam int QSHIFT = 2 * FRAC_W;

    localparam logic [SIZE_W-1:0] SIZE_RESET = 7'd64;

    localparam logic [KIND_W-1:0] KIND_WRITE = 1'b0;
    localparam logic [KIND_W-1:0] KIND_QUERY = 1'b1;

    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT = 1'b1;

    localparam int CNT_W = 3;
    localparam logic [CNT_W-1:0] CNT_ACC_FIRST = 3'd2;
    localparam logic [CNT_W-1:0] CNT_ACC_LAST  = 3'd5;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CALC,
        ST_DONE
    } state_t;

endpackage

`default_nettype wire

@@ hdl/bilinear_grid_sampler_core.sv @@
// Bilinear grid sampler: sample store, query sequencer and blend datapath.
// Depends on bgs_pkg and bilinear_grid_sampler_core_defines.svh.
//
// A write beat (tuser 0) stores one Q12.12 sample in the grid memory.
// A query beat (tuser 1) runs from acceptance until the result is loaded in the
// output register: the four neighbor cells go out one per cycle through the single read
// port of the grid memory, each is weighted through a two-stage multiply and summed, then
// the sum is rounded and saturated. The next beat is taken in the cycle after the result
// is loaded, so a new query is not taken before the last result is loaded; a result that the
// sink has not taken holds the sequencer until the output register frees. The output
// register holds the result until the sink takes it. Cells must be written before a query
// reads them; the memory has no reset.
`default_nettype none

`include "bilinear_grid_sampler_core_defines.svh"

module bilinear_grid_sampler_core #(
    parameter int GRID_SIDE = bgs_pkg::GRID_SIDE_DEF
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    // cell_x, cell_z, cell_value, pos_x, pos_z
    input  wire logic [bgs_pkg::IN_DATA_W-1:0]    s_tdata,
    // kind
    input  wire logic [bgs_pkg::KIND_W-1:0]       s_tuser,
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    // sample_out
    output logic [bgs_pkg::OUT_W-1:0]             m_tdata,
    input  wire logic                             cfg_we,
    input  wire logic [bgs_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [bgs_pkg::SIZE_W-1:0]       cfg_data
);

    localparam int IDX_W  = (GRID_SIDE > 2) ? $clog2(GRID_SIDE) : 1;
    localparam int CMP_W  = ($clog2(GRID_SIDE + 1) > bgs_pkg::SIZE_W) ?
                            $clog2(GRID_SIDE + 1) : bgs_pkg::SIZE_W;
    localparam int ADDR_W = 2 * IDX_W;
    localparam int DEPTH  = 1 << ADDR_W;

    localparam logic [CMP_W-1:0] SIDE_C = CMP_W'(GRID_SIDE);
    localparam logic [CMP_W-1:0] TWO_C  = CMP_W'(2);
    localparam logic [CMP_W-1:0] ONE_C  = CMP_W'(1);
    localparam logic signed [bgs_pkg::WGT_W-1:0] WGT_ONE = bgs_pkg::WGT_W'(256);
    localparam logic signed [bgs_pkg::RND_W-1:0] RND_HALF = bgs_pkg::RND_W'(32768);
    localparam logic [bgs_pkg::OUT_W-1:0] SAT_MAX = {1'b0, {(bgs_pkg::OUT_W-1){1'b1}}};
    localparam logic [bgs_pkg::OUT_W-1:0] SAT_MIN = {1'b1, {(bgs_pkg::OUT_W-1){1'b0}}};

    logic signed [bgs_pkg::VALUE_W-1:0] grid_mem [DEPTH];

    bgs_pkg::state_t state_reg, state_next;

    logic [bgs_pkg::SIZE_W-1:0] width_reg, height_reg;
    logic [bgs_pkg::CNT_W-1:0]  cnt_reg, cnt_next;

    logic [IDX_W-1:0]                    ix_reg, iz_reg;
    logic signed [bgs_pkg::WGT_W-1:0]    wx0_reg, wx1_reg, wz0_reg, wz1_reg;
    logic signed [bgs_pkg::WP_W-1:0]     wprod_reg, wprod_next;
    logic signed [bgs_pkg::VALUE_W-1:0]  rdata_reg;
    logic signed [bgs_pkg::TERM_W-1:0]   term_reg, term_next;
    logic signed [bgs_pkg::ACC_W-1:0]    acc_reg, acc_next;
    logic                                m_tvalid_reg;
    logic [bgs_pkg::OUT_W-1:0]           m_tdata_reg, m_tdata_next;

    logic [bgs_pkg::KIND_W-1:0]           in_kind;
    logic [bgs_pkg::CELL_W-1:0]           in_cx, in_cz;
    logic signed [bgs_pkg::VALUE_W-1:0]   in_value;
    logic [bgs_pkg::POS_W-1:0]            in_px, in_pz;

    logic                   in_beat, mem_we, out_free, out_load, last_acc;
    logic [CMP_W-1:0]       cx_ext, cz_ext, used_w, used_h, ix_calc, iz_calc;
    logic [ADDR_W-1:0]      wr_addr, rd_addr;
    logic [IDX_W-1:0]       rd_x, rd_z;
    logic [bgs_pkg::POS_W-1:0] wx1_u, wz1_u;
    logic signed [bgs_pkg::WGT_W-1:0] wsel_x, wsel_z;
    logic signed [bgs_pkg::RND_W-1:0] rnd_sum;
    logic [bgs_pkg::RND_W-bgs_pkg::QSHIFT-1:0] q_val;

    assign in_kind  = s_tuser;
    assign in_cx    = s_tdata[bgs_pkg::CELL_X_LSB +: bgs_pkg::CELL_W];
    assign in_cz    = s_tdata[bgs_pkg::CELL_Z_LSB +: bgs_pkg::CELL_W];
    assign in_value = s_tdata[bgs_pkg::VALUE_LSB +: bgs_pkg::VALUE_W];
    assign in_px    = s_tdata[bgs_pkg::POS_X_LSB +: bgs_pkg::POS_W];
    assign in_pz    = s_tdata[bgs_pkg::POS_Z_LSB +: bgs_pkg::POS_W];

    assign in_beat  = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;
    assign last_acc = (cnt_reg == bgs_pkg::CNT_ACC_LAST);

    // used grid size, clamped to [2, GRID_SIDE]
    always_comb
    begin
        used_w = CMP_W'(width_reg);
        if (used_w < TWO_C)
            used_w = TWO_C;
        else if (used_w > SIDE_C)
            used_w = SIDE_C;
        used_h = CMP_W'(height_reg);
        if (used_h < TWO_C)
            used_h = TWO_C;
        else if (used_h > SIDE_C)
            used_h = SIDE_C;
    end

    // cell pair and weights of an incoming query
    always_comb
    begin
        ix_calc = CMP_W'(in_px[bgs_pkg::POS_W-1:bgs_pkg::FRAC_W]);
        iz_calc = CMP_W'(in_pz[bgs_pkg::POS_W-1:bgs_pkg::FRAC_W]);
        if (ix_calc + ONE_C >= used_w)
            ix_calc = used_w - TWO_C;
        if (iz_calc + ONE_C >= used_h)
            iz_calc = used_h - TWO_C;
        wx1_u = in_px - {ix_calc[bgs_pkg::CELL_W-1:0], {bgs_pkg::FRAC_W{1'b0}}};
        wz1_u = in_pz - {iz_calc[bgs_pkg::CELL_W-1:0], {bgs_pkg::FRAC_W{1'b0}}};
    end

    assign cx_ext  = CMP_W'(in_cx);
    assign cz_ext  = CMP_W'(in_cz);
    assign wr_addr = {cx_ext[IDX_W-1:0], cz_ext[IDX_W-1:0]};

    assign rd_x    = ix_reg + IDX_W'(cnt_reg[0]);
    assign rd_z    = iz_reg + IDX_W'(cnt_reg[1]);
    assign rd_addr = {rd_x, rd_z};

    always_comb
    begin
        wsel_x     = cnt_reg[0] ? wx1_reg : wx0_reg;
        wsel_z     = cnt_reg[1] ? wz1_reg : wz0_reg;
        wprod_next = wsel_x * wsel_z;
        term_next  = rdata_reg * wprod_reg;
        if (cnt_reg == bgs_pkg::CNT_ACC_FIRST)
            acc_next = bgs_pkg::ACC_W'(term_reg);
        else
            acc_next = acc_reg + bgs_pkg::ACC_W'(term_reg);
    end

    // round to nearest, ties up, then saturate
    always_comb
    begin
        rnd_sum = bgs_pkg::RND_W'(acc_reg) + RND_HALF;
        q_val   = rnd_sum[bgs_pkg::RND_W-1:bgs_pkg::QSHIFT];
        if (!q_val[$bits(q_val)-1] && |q_val[$bits(q_val)-2:bgs_pkg::OUT_W-1])
            m_tdata_next = SAT_MAX;
        else if (q_val[$bits(q_val)-1] && !(&q_val[$bits(q_val)-2:bgs_pkg::OUT_W-1]))
            m_tdata_next = SAT_MIN;
        else
            m_tdata_next = q_val[bgs_pkg::OUT_W-1:0];
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            bgs_pkg::ST_IDLE:
            begin
                cnt_next = '0;
                if (in_beat && in_kind == bgs_pkg::KIND_QUERY)
                    state_next = bgs_pkg::ST_CALC;
            end
            bgs_pkg::ST_CALC:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (last_acc)
                    state_next = bgs_pkg::ST_DONE;
            end
            bgs_pkg::ST_DONE:
            begin
                if (out_free)
                    state_next = bgs_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = bgs_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        s_tready = 1'b0;
        mem_we   = 1'b0;
        out_load = 1'b0;
        case (state_reg)
            bgs_pkg::ST_IDLE:
            begin
                s_tready = 1'b1;
                mem_we   = s_tvalid && in_kind == bgs_pkg::KIND_WRITE &&
                           cx_ext < SIDE_C && cz_ext < SIDE_C;
            end
            bgs_pkg::ST_CALC:
            begin
                s_tready = 1'b0;
            end
            bgs_pkg::ST_DONE:
            begin
                out_load = out_free;
            end
            default:
            begin
                s_tready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            grid_mem[wr_addr] <= in_value;
        rdata_reg <= grid_mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= bgs_pkg::ST_IDLE;
            cnt_reg      <= '0;
            width_reg    <= bgs_pkg::SIZE_RESET;
            height_reg   <= bgs_pkg::SIZE_RESET;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    bgs_pkg::REG_GRID_WIDTH:  width_reg  <= cfg_data;
                    bgs_pkg::REG_GRID_HEIGHT: height_reg <= cfg_data;
                    default:                  width_reg  <= width_reg;
                endcase
            end
            if (out_load)
                m_tvalid_reg <= 1'b1;
            else if (m_tready)
                m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_beat)
        begin
            ix_reg  <= ix_calc[IDX_W-1:0];
            iz_reg  <= iz_calc[IDX_W-1:0];
            wx1_reg <= bgs_pkg::WGT_W'(wx1_u);
            wz1_reg <= bgs_pkg::WGT_W'(wz1_u);
            wx0_reg <= WGT_ONE - bgs_pkg::WGT_W'(wx1_u);
            wz0_reg <= WGT_ONE - bgs_pkg::WGT_W'(wz1_u);
        end
        wprod_reg <= wprod_next;
        term_reg  <= term_next;
        if (state_reg == bgs_pkg::ST_CALC && cnt_reg >= bgs_pkg::CNT_ACC_FIRST)
            acc_reg <= acc_next;
        if (out_load)
            m_tdata_reg <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    `BGS_ASSERT_NXT(a_query_starts_calc, in_beat && in_kind == bgs_pkg::KIND_QUERY,
        state_reg == bgs_pkg::ST_CALC && cnt_reg == '0,
        "query beat did not start the blend sequence")
    `BGS_ASSERT_IMP(a_write_only_idle, mem_we,
        state_reg == bgs_pkg::ST_IDLE && s_tvalid,
        "grid write outside an accepted beat")
    `BGS_ASSERT_IMP(a_calc_cnt_bound, state_reg == bgs_pkg::ST_CALC,
        cnt_reg <= bgs_pkg::CNT_ACC_LAST,
        "blend counter ran past the last accumulate")
    `BGS_ASSERT_IMP(a_result_from_done, $rose(m_tvalid_reg),
        $past(state_reg) == bgs_pkg::ST_DONE,
        "result beat raised outside the done step")

endmodule

`default_nettype wire
